// ===== src/erq_pkg.sv =====
// Shared types and constants for the event ring queue with overflow mark.
// Used by erq_store, event_ring_queue_overflow_mark and its checker.
`timescale 1ns / 1ps
`default_nettype none

package erq_pkg;

  localparam int DEFAULT_DEPTH = 32;

  localparam int ID_W  = 8;
  localparam int CNT_W = 32;
  localparam int AUX_W = 32;

  localparam logic [ID_W-1:0] OVERFLOW_ID_RESET = 8'hFF;

  // Operation codes carried on the func input.
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] count;
    logic [AUX_W-1:0] aux;
  } entry_t;

endpackage

`default_nettype wire

// ===== src/event_ring_queue_overflow_mark.sv =====
// Event ring queue with overflow mark: top level.
// An accepted request has its result registered on the output in the next cycle.
// Throughput: one request per cycle; the result register is the only stage,
// so a stalled result holds the request side until it is taken.
// Reset (rst, synchronous, active high) empties the queue and sets the
// overflow id to 255; entry storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module event_ring_queue_overflow_mark #(
  parameter int QUEUE_DEPTH = erq_pkg::DEFAULT_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [erq_pkg::ID_W-1:0]   cfg_wr_data,
  input  wire logic                       req_valid,
  output logic                            req_stall,
  input  wire logic                       func,
  input  wire logic [erq_pkg::ID_W-1:0]   event_id_in,
  input  wire logic [erq_pkg::CNT_W-1:0]  repeat_count_in,
  input  wire logic [erq_pkg::AUX_W-1:0]  aux_data_in,
  output logic                            rsp_valid,
  input  wire logic                       rsp_stall,
  output logic                            out_valid,
  output logic [erq_pkg::ID_W-1:0]        event_id_out,
  output logic [erq_pkg::CNT_W-1:0]       repeat_count_out,
  output logic [erq_pkg::AUX_W-1:0]       aux_data_out,
  output logic                            has_events
);
  import erq_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

  logic [ID_W-1:0]  overflow_id;
  logic [PTR_W-1:0] head_ptr, head_ptr_next;
  logic [PTR_W-1:0] tail_ptr, tail_ptr_next;
  logic             full_flag, full_flag_next;
  logic             has_next;
  logic             deq_hit;
  logic             accept;
  logic             is_enq;
  logic             nonempty;
  logic             id_we, data_we;
  entry_t           wr_entry;
  entry_t           rd_entry;

  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;
  assign is_enq    = (func == FUNC_ENQ);
  assign nonempty  = (head_ptr != tail_ptr) | full_flag;

  always_comb begin
    head_ptr_next  = head_ptr;
    tail_ptr_next  = tail_ptr;
    full_flag_next = full_flag;
    deq_hit        = 1'b0;
    id_we          = 1'b0;
    data_we        = 1'b0;
    wr_entry.id    = full_flag ? overflow_id : event_id_in;
    wr_entry.count = repeat_count_in;
    wr_entry.aux   = aux_data_in;
    if (is_enq) begin
      // When full, tail equals head, so the id write lands on the oldest entry.
      id_we = accept;
      if (!full_flag) begin
        data_we        = accept;
        tail_ptr_next  = (tail_ptr == LAST_SLOT) ? '0 : tail_ptr + 1'b1;
        full_flag_next = (tail_ptr_next == head_ptr);
      end
    end else if (nonempty) begin
      deq_hit        = 1'b1;
      head_ptr_next  = (head_ptr == LAST_SLOT) ? '0 : head_ptr + 1'b1;
      full_flag_next = 1'b0;
    end
    has_next = (head_ptr_next != tail_ptr_next) | full_flag_next;
  end

  erq_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk      (clk),
    .id_we    (id_we),
    .data_we  (data_we),
    .wr_ptr   (tail_ptr),
    .wr_entry (wr_entry),
    .rd_en    (accept),
    .rd_ptr   (head_ptr),
    .rd_entry (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_id <= OVERFLOW_ID_RESET;
      head_ptr    <= '0;
      tail_ptr    <= '0;
      full_flag   <= 1'b0;
      rsp_valid   <= 1'b0;
      out_valid   <= 1'b0;
      has_events  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        overflow_id <= cfg_wr_data;
      end
      if (accept) begin
        head_ptr   <= head_ptr_next;
        tail_ptr   <= tail_ptr_next;
        full_flag  <= full_flag_next;
        out_valid  <= deq_hit;
        has_events <= has_next;
        rsp_valid  <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Only a dequeue that found an entry shows stored data; all else reads zero.
  assign event_id_out     = out_valid ? rd_entry.id    : '0;
  assign repeat_count_out = out_valid ? rd_entry.count : '0;
  assign aux_data_out     = out_valid ? rd_entry.aux   : '0;

endmodule

`default_nettype wire

// ===== src/erq_store.sv =====
// Entry storage of the event ring queue: id, count and aux arrays.
// One write port, one registered read port. Depends on erq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module erq_store #(
  parameter int QUEUE_DEPTH = erq_pkg::DEFAULT_DEPTH,
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  wire logic               clk,
  input  wire logic               id_we,
  input  wire logic               data_we,
  input  wire logic [PTR_W-1:0]   wr_ptr,
  input  wire erq_pkg::entry_t    wr_entry,
  input  wire logic               rd_en,
  input  wire logic [PTR_W-1:0]   rd_ptr,
  output erq_pkg::entry_t         rd_entry
);
  import erq_pkg::*;

  logic [ID_W-1:0]  id_mem    [QUEUE_DEPTH];
  logic [CNT_W-1:0] count_mem [QUEUE_DEPTH];
  logic [AUX_W-1:0] aux_mem   [QUEUE_DEPTH];

  // The id array has its own enable so an overflow can retag the oldest
  // entry without touching its count and aux words.
  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[wr_ptr] <= wr_entry.id;
    end
    if (data_we) begin
      count_mem[wr_ptr] <= wr_entry.count;
      aux_mem[wr_ptr]   <= wr_entry.aux;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry.id    <= id_mem[rd_ptr];
      rd_entry.count <= count_mem[rd_ptr];
      rd_entry.aux   <= aux_mem[rd_ptr];
    end
  end

endmodule

`default_nettype wire

// ===== src/erq_checker.sv =====
// Port-level checker for the event ring queue, bound to the top level.
// Depends on erq_pkg and event_ring_queue_overflow_mark.
`timescale 1ns / 1ps
`default_nettype none

module erq_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       req_valid,
  input wire logic                       req_stall,
  input wire logic                       func,
  input wire logic                       rsp_valid,
  input wire logic                       rsp_stall,
  input wire logic                       out_valid,
  input wire logic [erq_pkg::ID_W-1:0]   event_id_out,
  input wire logic [erq_pkg::CNT_W-1:0]  repeat_count_out,
  input wire logic [erq_pkg::AUX_W-1:0]  aux_data_out,
  input wire logic                       has_events
);
  import erq_pkg::*;

  // A stalled result must hold its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(out_valid) &&
      $stable(event_id_out) && $stable(has_events))
    else $error("stalled result changed");

  // Every accepted request yields a result in the next cycle.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> rsp_valid)
    else $error("accepted request produced no result");

  // An enqueue never returns an entry and always leaves the queue nonempty.
  a_enq: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && func == FUNC_ENQ |=> !out_valid && has_events)
    else $error("enqueue result wrong");

  // A result without an entry carries zero data.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !out_valid |-> event_id_out == '0 &&
      repeat_count_out == '0 && aux_data_out == '0)
    else $error("empty result carries data");

endmodule

bind event_ring_queue_overflow_mark erq_checker u_erq_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req_valid),
  .req_stall        (req_stall),
  .func             (func),
  .rsp_valid        (rsp_valid),
  .rsp_stall        (rsp_stall),
  .out_valid        (out_valid),
  .event_id_out     (event_id_out),
  .repeat_count_out (repeat_count_out),
  .aux_data_out     (aux_data_out),
  .has_events       (has_events)
);

`default_nettype wire
